### src/dtfe_pkg.sv
// ----------------------------------------------------------------------------
// dtfe_pkg: shared types and helpers for the date/time field editor
// Request payload types, event and line codes, month lengths and the
// wraparound step used by the field update logic.
// ----------------------------------------------------------------------------
`default_nettype none

package dtfe_pkg;

	localparam logic [1:0] EV_PUSH = 2'd0;
	localparam logic [1:0] EV_CW   = 2'd1;
	localparam logic [1:0] EV_CCW  = 2'd2;

	localparam logic [1:0] LINE_DATE = 2'd0;
	localparam logic [1:0] LINE_TIME = 2'd1;

	localparam logic [1:0] COL_FIRST  = 2'd0;
	localparam logic [1:0] COL_SECOND = 2'd1;
	localparam logic [1:0] COL_LAST   = 2'd2;

	localparam logic [6:0] YEAR_MAX  = 7'd99;
	localparam logic [6:0] MONTH_MIN = 7'd1;
	localparam logic [6:0] MONTH_MAX = 7'd12;
	localparam logic [6:0] HOURS_MAX = 7'd23;
	localparam logic [6:0] MINSEC_MAX = 7'd59;
	localparam logic [4:0] FEB_LEAP  = 5'd29;
	localparam logic [4:0] FEB_PLAIN = 5'd28;
	localparam logic [3:0] MONTH_FEB = 4'd2;

	// Invalid month codes have a length of zero.
	localparam logic [4:0] MONTH_LEN [16] = '{
		5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
		5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0, 5'd0, 5'd0
	};

	typedef struct packed {
		logic [1:0] kind;
		logic [1:0] line_select;
		logic [6:0] year_in;
		logic [3:0] month_in;
		logic [4:0] day_in;
		logic [4:0] hours_in;
		logic [5:0] minutes_in;
		logic [5:0] seconds_in;
	} evt_t;

	typedef struct packed {
		logic [6:0] year_out;
		logic [3:0] month_out;
		logic [4:0] day_out;
		logic [4:0] hours_out;
		logic [5:0] minutes_out;
		logic [5:0] seconds_out;
		logic       write_date;
		logic       write_time;
		logic [1:0] column_now;
		logic       done_res;
	} res_t;

	function automatic logic [4:0] days_in(input logic [6:0] year, input logic [3:0] month);
		logic [4:0] len;
		if (month == MONTH_FEB) begin
			len = (year[1:0] == 2'd0) ? FEB_LEAP : FEB_PLAIN;
		end else begin
			len = MONTH_LEN[month];
		end
		return len;
	endfunction

	// Stepping up from hi or above gives lo; stepping down from lo or below gives hi.
	function automatic logic [6:0] wrap_step(input logic [6:0] v, input logic [6:0] lo,
			input logic [6:0] hi, input logic up);
		logic [6:0] r;
		if (up) begin
			r = (v >= hi) ? lo : v + 7'd1;
		end else begin
			r = (v <= lo) ? hi : v - 7'd1;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### src/dtfe_chan_if.sv
// ----------------------------------------------------------------------------
// dtfe_chan_if: valid/ready channel
// Carries one request of the given payload type per accepted handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface dtfe_chan_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### src/dtfe_update.sv
// ----------------------------------------------------------------------------
// dtfe_update: field update logic
// Applies one encoder event to the current date and time and the column
// pointer, giving the edited values, write flags, done flag and next column.
// ----------------------------------------------------------------------------
`default_nettype none

module dtfe_update (
	input  dtfe_pkg::evt_t     evt,
	input  logic [1:0]         column,
	output dtfe_pkg::res_t     res,
	output logic [1:0]         column_next
);
	import dtfe_pkg::*;

	logic       up;
	logic [6:0] year_w;
	logic [6:0] month_w;
	logic [6:0] tmp_w;
	logic [4:0] len;

	always_comb begin
		up      = (evt.kind == EV_CW);
		year_w  = '0;
		month_w = '0;
		tmp_w   = '0;
		len     = '0;

		res.year_out    = evt.year_in;
		res.month_out   = evt.month_in;
		res.day_out     = evt.day_in;
		res.hours_out   = evt.hours_in;
		res.minutes_out = evt.minutes_in;
		res.seconds_out = evt.seconds_in;
		res.write_date  = 1'b0;
		res.write_time  = 1'b0;
		res.done_res    = 1'b0;
		column_next     = column;

		if (evt.line_select == LINE_DATE || evt.line_select == LINE_TIME) begin
			unique case (evt.kind)
				EV_PUSH: begin
					if (column >= COL_LAST) begin
						column_next  = COL_FIRST;
						res.done_res = 1'b1;
					end else begin
						column_next = column + 2'd1;
					end
				end
				EV_CW, EV_CCW: begin
					if (evt.line_select == LINE_DATE) begin
						res.write_date = 1'b1;
						unique case (column)
							COL_FIRST: begin
								year_w       = wrap_step(evt.year_in, 7'd0, YEAR_MAX, up);
								len          = days_in(year_w, evt.month_in);
								res.year_out = year_w;
								res.day_out  = (evt.day_in > len) ? len : evt.day_in;
							end
							COL_SECOND: begin
								month_w = wrap_step({3'd0, evt.month_in}, MONTH_MIN,
									MONTH_MAX, up);
								len           = days_in(evt.year_in, month_w[3:0]);
								res.month_out = month_w[3:0];
								res.day_out   = (evt.day_in > len) ? len : evt.day_in;
							end
							COL_LAST: begin
								len = days_in(evt.year_in, evt.month_in);
								if (up) begin
									res.day_out = (evt.day_in >= len) ? 5'd1 : evt.day_in + 5'd1;
								end else begin
									res.day_out = (evt.day_in <= 5'd1) ? len : evt.day_in - 5'd1;
								end
							end
							default: ;
						endcase
					end else begin
						res.write_time = 1'b1;
						unique case (column)
							COL_FIRST: begin
								tmp_w = wrap_step({2'd0, evt.hours_in}, 7'd0, HOURS_MAX, up);
								res.hours_out = tmp_w[4:0];
							end
							COL_SECOND: begin
								tmp_w = wrap_step({1'b0, evt.minutes_in}, 7'd0, MINSEC_MAX, up);
								res.minutes_out = tmp_w[5:0];
							end
							COL_LAST: begin
								tmp_w = wrap_step({1'b0, evt.seconds_in}, 7'd0, MINSEC_MAX, up);
								res.seconds_out = tmp_w[5:0];
							end
							default: ;
						endcase
					end
				end
				default: ;
			endcase
		end

		res.column_now = column_next;
	end

endmodule

`default_nettype wire

### src/date_time_field_editor.sv
// ----------------------------------------------------------------------------
// date_time_field_editor: rotary-encoder date and time field editor
// Edits the date or time line one field at a time from encoder events.
// ----------------------------------------------------------------------------
//  Channel | Direction | Payload
//  evt     | in        | kind, line_select, current date and time
//  res     | out       | edited date and time, write flags, column, done
//
// Each request passes an input register and a result register.
// One request is accepted per cycle while the result is not stalled.
// The column pointer is updated as a request moves from the input register
// to the result register, so back-to-back events see each other's effect.
// Reset clears the valid bits and returns the column to the first field.
// A stall holds res_s2 and a full evt_s1; evt.ready falls only then.
`default_nettype none

module date_time_field_editor (
	input  logic                 clk,
	input  logic                 arst_n,
	dtfe_chan_if.sink            evt,
	dtfe_chan_if.source          res
);
	import dtfe_pkg::*;

	logic       valid_s1;
	evt_t       evt_s1;
	logic       valid_s2;
	res_t       res_s2;
	logic [1:0] column_q;

	res_t       res_comb;
	logic [1:0] column_next;
	logic       adv_s1;

	assign adv_s1    = !valid_s2 || res.ready;
	assign evt.ready = !valid_s1 || adv_s1;

	dtfe_update u_update (
		.evt         (evt_s1),
		.column      (column_q),
		.res         (res_comb),
		.column_next (column_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			column_q <= COL_FIRST;
		end else begin
			if (evt.ready) begin
				valid_s1 <= evt.valid;
			end
			if (adv_s1) begin
				valid_s2 <= valid_s1;
				if (valid_s1) begin
					column_q <= column_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (evt.ready && evt.valid) begin
			evt_s1 <= evt.data;
		end
		if (adv_s1 && valid_s1) begin
			res_s2 <= res_comb;
		end
	end

	assign res.valid = valid_s2;
	assign res.data  = res_s2;

	a_column_range: assert property (@(posedge clk) disable iff (!arst_n)
		column_q != 2'd3)
		else $error("column pointer left the field range");

	a_done_first: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.done_res |-> res_s2.column_now == COL_FIRST)
		else $error("done without return to the first field");

	a_one_line: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(res_s2.write_date && res_s2.write_time))
		else $error("both lines written by one event");

	a_column_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && valid_s1 |=> res_s2.column_now == column_q)
		else $error("result column differs from the pointer");

	a_write_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && (res_s2.write_date || res_s2.write_time) |-> !res_s2.done_res)
		else $error("write flag and done raised together");

endmodule

`default_nettype wire
